@@ hdl/rfc_pkg.sv @@
// ----------------------------------------------------------------------------
// rfc_pkg: shared types and constants for the reply frame checker
// Holds the frame constants, the status codes, the register indexes and the
// CRC-8 (poly 0x07) byte update used by the checker.
// ----------------------------------------------------------------------------
`default_nettype none

package rfc_pkg;

    localparam logic [7:0] SYNC_BYTE  = 8'h05;
    localparam logic [7:0] CRC_POLY   = 8'h07;
    localparam logic [2:0] LAST_INDEX = 3'd7;

    // Register indexes on the configuration port
    localparam logic CFG_NODE_ADDRESS     = 1'b0;
    localparam logic CFG_REGISTER_ADDRESS = 1'b1;

    typedef enum logic [2:0] {
        STATUS_OK       = 3'd0,
        STATUS_BAD_SYNC = 3'd1,
        STATUS_BAD_ADDR = 3'd2,
        STATUS_BAD_REG  = 3'd3,
        STATUS_BAD_CRC  = 3'd4
    } rfc_status_t;

    // One received byte as it travels from the input stage
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
    } rfc_item_t;

    // One frame verdict as it travels to the output stage
    typedef struct packed {
        rfc_status_t status;
        logic [31:0] reg_value;
    } rfc_result_t;

    // CRC-8 update: data bits fed LSB first, CRC register shifted MSB first
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        logic       fb;
        c = crc;
        for (int i = 0; i < 8; i++) begin
            fb = c[7] ^ data[i];
            c  = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ hdl/rfc_in_reg.sv @@
// ----------------------------------------------------------------------------
// rfc_in_reg: input register stage
// Captures one received byte transaction and holds it until the checker
// takes it; refills in the same cycle the held item drains.
// ----------------------------------------------------------------------------
`default_nettype none

module rfc_in_reg
    import rfc_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire rfc_item_t  s_item,
    output logic            item_valid,
    output rfc_item_t       item,
    input  wire logic       item_take
);

    logic      valid_reg;
    logic      valid_next;
    rfc_item_t item_reg;

    // Accept when empty or when the held item leaves this cycle
    assign s_ready    = !valid_reg || item_take;
    assign valid_next = (s_valid && s_ready) || (valid_reg && !item_take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Load payload on accept
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

@@ hdl/rfc_check.sv @@
// ----------------------------------------------------------------------------
// rfc_check: frame state and header/CRC checks
// Advances the byte count, CRC and value for each byte, records the first
// header error and forms the verdict on the last byte of a frame.
// ----------------------------------------------------------------------------
`default_nettype none

module rfc_check
    import rfc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic [6:0]  node_address,
    input  wire logic [7:0]  register_address,
    input  wire logic        item_valid,
    input  wire rfc_item_t   item,
    output logic             item_take,
    output logic             res_valid,
    output rfc_result_t      res,
    input  wire logic        res_ready
);

    logic [2:0]  count_reg,  count_next;
    logic [7:0]  crc_reg,    crc_next;
    logic [31:0] acc_reg,    acc_next;
    rfc_status_t err_reg,    err_next;

    logic [2:0]  idx;
    logic [7:0]  crc_cur;
    logic [31:0] acc_cur;
    rfc_status_t err_cur;
    logic        last;
    logic [1:0]  lane;
    logic [7:0]  want_addr;
    rfc_status_t verdict;

    // Restart framing on frame_start
    always_comb begin
        if (item.frame_start) begin
            idx     = 3'd0;
            crc_cur = 8'h00;
            acc_cur = 32'h0;
            err_cur = STATUS_OK;
        end else begin
            idx     = count_reg;
            crc_cur = crc_reg;
            acc_cur = acc_reg;
            err_cur = err_reg;
        end
    end

    assign last      = (idx == LAST_INDEX);
    assign lane      = idx[1:0] + 2'd1;
    assign want_addr = {node_address, 1'b0};

    // The last byte waits for room in the output stage
    assign item_take = item_valid && (!last || res_ready);

    // Verdict: first header error, else CRC compare
    always_comb begin
        if (err_cur != STATUS_OK) begin
            verdict = err_cur;
        end else if (item.rx_byte != crc_cur) begin
            verdict = STATUS_BAD_CRC;
        end else begin
            verdict = STATUS_OK;
        end
    end

    assign res_valid     = item_valid && last;
    assign res.status    = verdict;
    assign res.reg_value = (verdict == STATUS_OK) ? acc_cur : 32'h0;

    // Next frame state
    always_comb begin
        count_next = idx + 3'd1;
        crc_next   = crc8_byte(crc_cur, item.rx_byte);
        acc_next   = acc_cur;
        err_next   = err_cur;
        if (last) begin
            count_next = 3'd0;
            crc_next   = 8'h00;
            acc_next   = 32'h0;
            err_next   = STATUS_OK;
        end else begin
            case (idx)
                3'd0: begin
                    if (item.rx_byte != SYNC_BYTE && err_cur == STATUS_OK)
                        err_next = STATUS_BAD_SYNC;
                end
                3'd1: begin
                    if (item.rx_byte != want_addr && err_cur == STATUS_OK)
                        err_next = STATUS_BAD_ADDR;
                end
                3'd2: begin
                    if (item.rx_byte != register_address && err_cur == STATUS_OK)
                        err_next = STATUS_BAD_REG;
                end
                default: begin
                    acc_next[{lane, 3'b000} +: 8] = item.rx_byte;
                end
            endcase
        end
    end

    // Advance state when a byte is consumed
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 3'd0;
            crc_reg   <= 8'h00;
            acc_reg   <= 32'h0;
            err_reg   <= STATUS_OK;
        end else if (item_take) begin
            count_reg <= count_next;
            crc_reg   <= crc_next;
            acc_reg   <= acc_next;
            err_reg   <= err_next;
        end
    end

    // A consumed last byte leaves a cleared frame behind
    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (item_take && last) |=> (count_reg == 3'd0 && crc_reg == 8'h00
                                 && acc_reg == 32'h0 && err_reg == STATUS_OK))
        else $error("frame state not cleared after last byte");

    // A failed verdict never carries a value
    a_zero_on_error: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res.status != STATUS_OK) |-> (res.reg_value == 32'h0))
        else $error("value not zero on failed frame");

    // The value accumulator only fills once the header has passed
    a_acc_empty_in_header: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 3'd0 || count_reg == 3'd1 || count_reg == 3'd2
         || count_reg == 3'd3) |-> (acc_reg == 32'h0))
        else $error("value gathered before value bytes");

endmodule

`default_nettype wire

@@ hdl/rfc_out_reg.sv @@
// ----------------------------------------------------------------------------
// rfc_out_reg: result register stage
// Holds one frame verdict until the receiver takes it and reloads in the
// same cycle the held verdict is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module rfc_out_reg
    import rfc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        res_valid,
    input  wire rfc_result_t res,
    output logic             res_ready,
    output logic             m_valid,
    output rfc_result_t      m_res,
    input  wire logic        m_ready
);

    logic        valid_reg;
    logic        valid_next;
    rfc_result_t res_reg;

    // Load when empty or when the held verdict leaves
    assign res_ready  = !valid_reg || m_ready;
    assign valid_next = (res_valid && res_ready) || (valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            res_reg <= res;
        end
    end

    assign m_valid = valid_reg;
    assign m_res   = res_reg;

endmodule

`default_nettype wire

@@ hdl/reply_frame_checker.sv @@
// ----------------------------------------------------------------------------
// reply_frame_checker: 8-byte register reply frame checker
// Feed received bytes on the s_ channel (s_rx_byte, s_frame_start) with
// valid/ready. Each 8-byte frame (sync 0x05, node address << 1, register
// address, 32-bit value LSB first, CRC-8 poly 0x07) yields one transaction
// on the m_ channel: m_status (0 ok, 1 sync, 2 address, 3 register, 4 CRC,
// first failed check) and m_reg_value (zero unless ok). Bytes 0 to 6
// produce no output. s_frame_start restarts framing and drops any partial
// frame.
// A verdict passes from the input register through the check logic into the
// result register, which drives m_valid.
// Throughput: one byte per cycle unless a last byte stalls; the per-byte CRC
// network sits between the input register and the result register.
// Stall: while a verdict waits on m_ready, bytes 0 to 6 of the next frame
// still flow; only the next last byte waits, after which s_ready drops.
// Reset (aresetn low, synchronous): clears both stages, the frame state and
// the node/register address registers. Write cfg_* only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module reply_frame_checker
    import rfc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [7:0]  cfg_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_rx_byte,
    input  wire logic        s_frame_start,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_status,
    output logic [31:0]      m_reg_value
);

    logic [6:0]  node_address_reg;
    logic [7:0]  register_address_reg;

    rfc_item_t   s_item;
    rfc_item_t   item;
    logic        item_valid;
    logic        item_take;
    rfc_result_t res;
    logic        res_valid;
    logic        res_ready;
    rfc_result_t m_res;

    // Configuration register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_address_reg     <= 7'd0;
            register_address_reg <= 8'd0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_NODE_ADDRESS:     node_address_reg     <= cfg_wdata[6:0];
                CFG_REGISTER_ADDRESS: register_address_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign s_item.rx_byte     = s_rx_byte;
    assign s_item.frame_start = s_frame_start;

    rfc_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    rfc_check u_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .node_address     (node_address_reg),
        .register_address (register_address_reg),
        .item_valid       (item_valid),
        .item             (item),
        .item_take        (item_take),
        .res_valid        (res_valid),
        .res              (res),
        .res_ready        (res_ready)
    );

    rfc_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready),
        .m_valid   (m_valid),
        .m_res     (m_res),
        .m_ready   (m_ready)
    );

    assign m_status    = m_res.status;
    assign m_reg_value = m_res.reg_value;

endmodule

`default_nettype wire
